>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define SRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRF_ASSERT_IMP(lbl, ante, cons, msg)

`define SRF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/srf_pkg.sv
`default_nettype none

package srf_pkg;

  // Field and state widths
  localparam int BS_W       = 14;
  localparam int POS_W      = 13;
  localparam int RL_W       = 17;
  localparam int SL_W       = 13;
  localparam int MF_W       = 6;
  localparam int PADC_W     = 6;
  localparam int SHOWN_W    = 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 14;

  // Block geometry limits
  localparam logic [BS_W-1:0]    MIN_BLOCK    = 14'd64;
  localparam logic [BS_W-1:0]    MAX_BLOCK    = 14'd8192;
  localparam logic [MF_W-1:0]    CW_LEN       = 6'd5;
  localparam logic [MF_W-1:0]    MAX_MIN_FREE = 6'd48;
  localparam logic [SHOWN_W-1:0] SEG_LEN_CAP  = 14'd9999;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTED  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR   = 8'd3;

  // Register reset values
  localparam logic            RST_SEGMENTED  = 1'b1;
  localparam logic [BS_W-1:0] RST_BLOCK_SIZE = 14'd2048;
  localparam logic [MF_W-1:0] RST_MIN_FREE   = 6'd5;
  localparam logic [7:0]      RST_PAD_CHAR   = 8'd32;

  // Segment type digits
  localparam logic [1:0] TYP_WHOLE  = 2'd0;
  localparam logic [1:0] TYP_FIRST  = 2'd1;
  localparam logic [1:0] TYP_MIDDLE = 2'd2;
  localparam logic [1:0] TYP_LAST   = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Decimal place values for the control word length
  localparam logic [SHOWN_W-1:0] PLACE_THOU = 14'd1000;
  localparam logic [SHOWN_W-1:0] PLACE_HUND = 14'd100;
  localparam logic [SHOWN_W-1:0] PLACE_TENS = 14'd10;

  // Command queue (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Clamped configuration as seen by the datapath
  typedef struct packed {
    logic            seg;
    logic [BS_W-1:0] bs;
    logic [MF_W-1:0] mf;
    logic [7:0]      pad;
  } cfg_t;

  // One classified input transaction, handed from front to back
  typedef struct packed {
    logic               misuse;
    logic [PADC_W-1:0]  pad_cnt;
    logic               cw;
    logic [1:0]         typ;
    logic [SHOWN_W-1:0] shown;
    logic [7:0]         data;
    logic [POS_W-1:0]   pos0;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end byte sequencer phases
  typedef enum logic [2:0] {
    PH_PAD,
    PH_TYPE,
    PH_THOU,
    PH_HUND,
    PH_TENS,
    PH_ONES,
    PH_DATA
  } ph_t;

  // One decimal digit of v at the given place (v < 10 * place)
  function automatic logic [3:0] digit_of(input logic [SHOWN_W-1:0] v,
                                          input logic [SHOWN_W-1:0] place);
    logic [3:0] d;
    d = 4'd0;
    for (int j = 1; j <= 9; j++) begin
      if ({4'b0, v} >= 18'(j) * {4'b0, place}) d = 4'(j);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/srf_in_if.sv
`default_nettype none

interface srf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        record_start;
  logic [16:0] record_length;

  modport source (output valid, output data_byte, output record_start,
                  output record_length, input ready);
  modport sink   (input valid, input data_byte, input record_start,
                  input record_length, output ready);
endinterface

`default_nettype wire

>>> rtl/srf_out_if.sv
`default_nettype none

interface srf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       block_done;
  logic       misuse;
  logic       last;

  modport source (output valid, output out_byte, output block_done,
                  output misuse, output last, input ready);
  modport sink   (input valid, input out_byte, input block_done,
                  input misuse, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/srf_cfg_if.sv
`default_nettype none

interface srf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/srf_front.sv
`default_nettype none

module srf_front (
  input  logic             clk,
  input  logic             rst_n,
  srf_in_if.sink           in_ch,
  input  srf_pkg::cfg_t    cfg,
  input  srf_pkg::q_stat_t qs,
  output logic             push,
  output srf_pkg::cmd_t    cmd
);
  import srf_pkg::*;

  logic [POS_W-1:0] block_pos_r, block_pos_nxt;
  logic [RL_W-1:0]  rec_left_r, rec_left_nxt;
  logic [SL_W-1:0]  seg_left_r, seg_left_nxt;
  logic             first_seg_r, first_seg_nxt;

  // Take a transaction whenever the queue has a free slot
  assign in_ch.ready = !qs.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the transaction and work out the record state it leaves behind
  always_comb begin
    logic [POS_W-1:0]   pos0, pos1, p2, pos_after;
    logic [BS_W-1:0]    room0, room1, p3;
    logic [RL_W-1:0]    rl_eff, rl_new;
    logic [SL_W-1:0]    sl_eff, sl_cw, seg_len;
    logic               fs_eff, bad, pad1, pad2, need_cw, split;
    logic [SHOWN_W-1:0] shown_raw;

    pos0    = ({1'b0, block_pos_r} >= cfg.bs) ? '0 : block_pos_r;
    room0   = cfg.bs - {1'b0, pos0};
    bad     = (in_ch.record_start && in_ch.record_length == '0) ||
              (!in_ch.record_start && rec_left_r == '0);
    rl_eff  = in_ch.record_start ? in_ch.record_length : rec_left_r;
    sl_eff  = in_ch.record_start ? '0 : seg_left_r;
    fs_eff  = in_ch.record_start ? 1'b1 : first_seg_r;

    // Block tail padding: new record with too little room, or no room for a
    // control word after a size change
    pad1    = in_ch.record_start && cfg.seg && room0 <= {8'b0, cfg.mf};
    need_cw = cfg.seg && sl_eff == '0;
    pad2    = !pad1 && need_cw && room0 < 14'(CW_LEN + 6'd1);
    pos1    = (pad1 || pad2) ? '0 : pos0;
    room1   = (pad1 || pad2) ? cfg.bs : room0;

    // Segment length and type
    split   = ({1'b0, rl_eff} + 18'(CW_LEN)) > {4'b0, room1};
    seg_len = split ? SL_W'(room1 - 14'(CW_LEN)) : rl_eff[SL_W-1:0];
    shown_raw = {1'b0, seg_len} + 14'(CW_LEN);

    // Position after the last byte of this transaction
    p2        = pos1 + (need_cw ? 13'(CW_LEN) : 13'd0);
    p3        = {1'b0, p2} + 14'd1;
    pos_after = (p3 >= cfg.bs) ? '0 : p3[POS_W-1:0];

    rl_new = rl_eff - 17'd1;
    sl_cw  = need_cw ? seg_len : sl_eff;

    cmd.misuse  = bad;
    cmd.pad_cnt = (pad1 || pad2) ? room0[PADC_W-1:0] : '0;
    cmd.cw      = need_cw;
    cmd.typ     = split ? (fs_eff ? TYP_FIRST : TYP_MIDDLE)
                        : (fs_eff ? TYP_WHOLE : TYP_LAST);
    cmd.shown   = (shown_raw > SEG_LEN_CAP) ? SEG_LEN_CAP : shown_raw;
    cmd.data    = in_ch.data_byte;
    cmd.pos0    = pos0;

    block_pos_nxt = block_pos_r;
    rec_left_nxt  = rec_left_r;
    seg_left_nxt  = seg_left_r;
    first_seg_nxt = first_seg_r;
    if (push) begin
      if (bad) begin
        block_pos_nxt = pos0;
      end else begin
        block_pos_nxt = pos_after;
        rec_left_nxt  = rl_new;
        if (rl_new == '0) begin
          seg_left_nxt  = '0;
          first_seg_nxt = 1'b1;
        end else begin
          seg_left_nxt  = (sl_cw != '0) ? sl_cw - 13'd1 : sl_cw;
          first_seg_nxt = need_cw ? 1'b0 : fs_eff;
        end
      end
    end
  end

  // Record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_pos_r <= '0;
      rec_left_r  <= '0;
      seg_left_r  <= '0;
      first_seg_r <= 1'b1;
    end else begin
      block_pos_r <= block_pos_nxt;
      rec_left_r  <= rec_left_nxt;
      seg_left_r  <= seg_left_nxt;
      first_seg_r <= first_seg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srf_queue.sv
`default_nettype none

module srf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srf_pkg::cmd_t    wr_cmd,
  input  logic             pop,
  output srf_pkg::cmd_t    head,
  output srf_pkg::q_stat_t qs
);
  import srf_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head     = slot_r[rd_ptr_r];
  assign qs.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qs.empty = (cnt_r == '0);

  // Pointer and fill bookkeeping; push and pop may share a cycle
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srf_back.sv
`default_nettype none

module srf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  srf_pkg::cfg_t    cfg,
  input  srf_pkg::cmd_t    head,
  input  srf_pkg::q_stat_t qs,
  output logic             pop,
  srf_out_if.source        out_ch
);
  import srf_pkg::*;

  ph_t                ph_r, ph_nxt, ph_eff;
  logic [PADC_W-1:0]  pcnt_r, pcnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               first_r, first_nxt;
  logic [SHOWN_W-1:0] rem_r, rem_nxt;
  logic               out_valid_r;
  logic [7:0]         out_byte_r, byte_c;
  logic               done_r, done_c;
  logic               mis_r, mis_c;
  logic               last_r, last_c;
  logic               emit;

  // One byte per cycle while a command waits and the output slot frees up
  assign emit = !qs.empty && (!out_valid_r || out_ch.ready);

  // Skip the pad phase once its count is used up
  always_comb begin
    if (ph_r == PH_PAD && pcnt_r == head.pad_cnt) begin
      ph_eff = head.cw ? PH_TYPE : PH_DATA;
    end else begin
      ph_eff = ph_r;
    end
  end

  // Next phase
  always_comb begin
    ph_nxt   = ph_r;
    pcnt_nxt = pcnt_r;
    if (emit) begin
      if (pop) begin
        ph_nxt   = PH_PAD;
        pcnt_nxt = '0;
      end else begin
        unique case (ph_eff)
          PH_PAD:  pcnt_nxt = pcnt_r + 6'd1;
          PH_TYPE: ph_nxt   = PH_THOU;
          PH_THOU: ph_nxt   = PH_HUND;
          PH_HUND: ph_nxt   = PH_TENS;
          PH_TENS: ph_nxt   = PH_ONES;
          PH_ONES: ph_nxt   = PH_DATA;
          PH_DATA: ph_nxt   = PH_DATA;
          default: ph_nxt   = PH_PAD;
        endcase
      end
    end
  end

  // Byte selection, digit extraction and block position
  always_comb begin
    logic [SHOWN_W-1:0] src, place;
    logic [3:0]         d;
    logic [POS_W-1:0]   cur_pos;
    logic [BS_W-1:0]    pos_inc;

    src   = (ph_eff == PH_THOU) ? head.shown : rem_r;
    place = (ph_eff == PH_THOU) ? PLACE_THOU :
            (ph_eff == PH_HUND) ? PLACE_HUND : PLACE_TENS;
    d     = digit_of(src, place);

    cur_pos = first_r ? head.pos0 : pos_r;
    pos_inc = {1'b0, cur_pos} + 14'd1;

    byte_c  = head.data;
    last_c  = 1'b0;
    mis_c   = 1'b0;
    done_c  = (pos_inc == cfg.bs);
    rem_nxt = rem_r;
    unique case (ph_eff)
      PH_PAD:  byte_c = cfg.pad;
      PH_TYPE: byte_c = ASCII_ZERO + {6'b0, head.typ};
      PH_THOU, PH_HUND, PH_TENS: begin
        byte_c  = ASCII_ZERO + {4'b0, d};
        rem_nxt = src - SHOWN_W'(18'(d) * 18'(place));
      end
      PH_ONES: byte_c = ASCII_ZERO + {4'b0, rem_r[3:0]};
      PH_DATA: begin
        byte_c = head.data;
        last_c = 1'b1;
      end
      default: byte_c = head.data;
    endcase

    // Dropped byte: single flagged result, position untouched
    if (head.misuse) begin
      byte_c = '0;
      done_c = 1'b0;
      mis_c  = 1'b1;
      last_c = 1'b1;
    end

    pop       = emit && last_c;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    if (emit) begin
      first_nxt = pop;
      if (!head.misuse) begin
        pos_nxt = done_c ? '0 : pos_inc[POS_W-1:0];
      end
    end
  end

  // Sequencer and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_PAD;
      pcnt_r      <= '0;
      pos_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      pcnt_r  <= pcnt_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register and digit remainder
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_c;
      done_r     <= done_c;
      mis_r      <= mis_c;
      last_r     <= last_c;
      rem_r      <= rem_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.block_done = done_r;
  assign out_ch.misuse     = mis_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

>>> rtl/segmented_record_framer_unit.sv
// Channel   Dir  Handshake             Payload
// in_ch     in   valid / ready         data_byte, record_start, record_length
// out_ch    out  valid / ready         out_byte, block_done, misuse, last
// cfg_ch    in   valid / ready (=1)    index, data
//
// While out_ch is ready, one byte leaves per cycle; the back-end sequencer emits 1 + P + C
// bytes per input transaction, P being block tail padding (0..48) and C 5
// when a control word opens a segment. Plain data streams one per cycle unless stalled.
// Input is taken whenever the two-entry command queue has room, so the front
// runs ahead while the output register is stalled or a burst is in flight.
// Reset is synchronous; all state is in flip-flops, no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module segmented_record_framer_unit (
  input  logic       clk,
  input  logic       rst_n,
  srf_in_if.sink     in_ch,
  srf_out_if.source  out_ch,
  srf_cfg_if.sink    cfg_ch
);
  import srf_pkg::*;

  logic            seg_r;
  logic [BS_W-1:0] bs_r;
  logic [MF_W-1:0] mf_r;
  logic [7:0]      pad_r;
  cfg_t            cfg;
  cmd_t            q_wr_cmd;
  cmd_t            q_head;
  q_stat_t         qs;
  logic            q_push;
  logic            q_pop;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= RST_SEGMENTED;
      bs_r  <= RST_BLOCK_SIZE;
      mf_r  <= RST_MIN_FREE;
      pad_r <= RST_PAD_CHAR;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SEGMENTED:  seg_r <= cfg_ch.data[0];
        REG_BLOCK_SIZE: bs_r  <= cfg_ch.data[BS_W-1:0];
        REG_MIN_FREE:   mf_r  <= cfg_ch.data[MF_W-1:0];
        REG_PAD_CHAR:   pad_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Clamp block size and threshold to their working ranges
  always_comb begin
    cfg.seg = seg_r;
    cfg.bs  = (bs_r < MIN_BLOCK) ? MIN_BLOCK : (bs_r > MAX_BLOCK) ? MAX_BLOCK : bs_r;
    cfg.mf  = (mf_r < CW_LEN) ? CW_LEN : (mf_r > MAX_MIN_FREE) ? MAX_MIN_FREE : mf_r;
    cfg.pad = pad_r;
  end

  srf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .qs    (qs),
    .push  (q_push),
    .cmd   (q_wr_cmd)
  );

  srf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .head   (q_head),
    .qs     (qs)
  );

  srf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (q_head),
    .qs     (qs),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // A dropped byte gives a lone, flagged, zero result
  `SRF_ASSERT_IMP(a_misuse_shape, out_ch.valid && out_ch.misuse,
                  out_ch.last && !out_ch.block_done && out_ch.out_byte == 8'd0,
                  "misuse result malformed")

  // A taken transaction is queued by the next cycle
  `SRF_ASSERT_NXT(a_push_lands, q_push, !qs.empty, "queued command missing")

  // Queue never pops empty, and its status is consistent whenever it pops
  `SRF_ASSERT_IMP(a_queue_sane, q_pop, !qs.empty && !(qs.full && qs.empty), "queue underflow")

endmodule

`default_nettype wire
